@@ hdl/small_matrix_alu_unit_defines.svh @@
// ----------------------------------------------------------------------------
// small_matrix_alu_unit_defines
// Assertion macros used by smau_back.
// ----------------------------------------------------------------------------
`ifndef SMALL_MATRIX_ALU_UNIT_DEFINES_SVH
`define SMALL_MATRIX_ALU_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SMAU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SMAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/smau_pkg.sv @@
// ----------------------------------------------------------------------------
// smau_pkg
// Types, codes and sizes shared by the matrix ALU modules.
// ----------------------------------------------------------------------------
package smau_pkg;

   localparam int DIM         = 4;
   localparam int CELLS       = DIM * DIM;
   localparam int IDX_W       = $clog2(CELLS);
   localparam int DIM_W       = $clog2(DIM);
   localparam int ACC_W       = 64 + $clog2(DIM) + 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // request type codes
   localparam logic [1:0] REQ_LOAD_A = 2'd0;
   localparam logic [1:0] REQ_LOAD_B = 2'd1;
   localparam logic [1:0] REQ_RUN    = 2'd2;

   typedef enum logic [2:0] {
      OP_ADD       = 3'd0,
      OP_SUB       = 3'd1,
      OP_MUL       = 3'd2,
      OP_SCALE     = 3'd3,
      OP_TRANSPOSE = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      CMD_LOAD_A,
      CMD_LOAD_B,
      CMD_RUN
   } cmd_kind_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [3:0]         elem_index;
      logic signed [31:0] elem_value;
      logic [2:0]         op_code;
      logic signed [31:0] scale_factor;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]         out_index;
      logic signed [31:0] out_value;
      logic               out_last;
      logic               out_saturated;
   } rsp_payload_type;

   // classified command: operand is the load value or the scalar
   typedef struct packed {
      cmd_kind_type       kind;
      logic [3:0]         index;
      op_type             op;
      logic signed [31:0] operand;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

@@ hdl/small_matrix_alu_unit.sv @@
// ----------------------------------------------------------------------------
// small_matrix_alu_unit
// Fixed-point 4x4 matrix ALU: loads A/B elements, runs add, subtract,
// multiply, scale and transpose, and streams the result row-major.
// ----------------------------------------------------------------------------
//
//   channel   ports                        direction   moves
//   --------  ---------------------------  ---------   ---------------------------
//   request   req_valid/req_ready/req_data in          load A, load B or run
//   response  rsp_valid/rsp_ready/rsp_data out         one result element
//
// Sequencing: a load is written when it is popped in idle. A run steps each
//   result element through read, multiply, accumulate and finish on the
//   single read port of each matrix RAM; multiply repeats read, multiply and
//   accumulate for each inner term before finish. A run starts when it is
//   popped in idle.
// Reset clears the queue, the sequencer and the output valid; matrix contents
//   stay undefined until loaded.
// Stalls: the output register holds an element until its transfer and the
//   sequencer waits at the finish step; the two-entry queue keeps taking
//   requests until it fills, then req_ready drops.
//
module small_matrix_alu_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  smau_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output smau_pkg::rsp_payload_type rsp_data
);
   import smau_pkg::*;

   // command path from front to back
   logic             push;
   cmd_type          push_cmd;
   logic             pop;
   cmd_type          head_cmd;
   queue_status_type q_status;

   // Front: classify each request transfer; drop out-of-range loads, unused
   // request types and unused operation codes before they reach the queue.
   smau_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   // Queue: hold commands in order so the front keeps accepting while the
   // back is busy with a run or stalled on the response side.
   smau_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   // Back: write loads into the matrix RAMs, walk a run element by element
   // and present each result from the output register.
   smau_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_cmd  (head_cmd),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ hdl/smau_ram.sv @@
// ----------------------------------------------------------------------------
// smau_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smau_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/smau_front.sv @@
// ----------------------------------------------------------------------------
// smau_front
// Accept requests, drop the ignored ones and push commands to the queue.
// ----------------------------------------------------------------------------
module smau_front (
   input  logic                       req_valid,
   output logic                       req_ready,
   input  smau_pkg::req_payload_type  req_data,
   input  smau_pkg::queue_status_type q_status,
   output logic                       push,
   output smau_pkg::cmd_type          push_cmd
);
   import smau_pkg::*;

   logic keep;

   always_comb begin
      keep              = 1'b0;
      push_cmd.kind     = CMD_RUN;
      push_cmd.index    = req_data.elem_index;
      push_cmd.op       = op_type'(req_data.op_code);
      push_cmd.operand  = req_data.scale_factor;
      case (req_data.req_type)
         REQ_LOAD_A: begin
            keep             = (32'(req_data.elem_index) < CELLS);
            push_cmd.kind    = CMD_LOAD_A;
            push_cmd.operand = req_data.elem_value;
         end
         REQ_LOAD_B: begin
            keep             = (32'(req_data.elem_index) < CELLS);
            push_cmd.kind    = CMD_LOAD_B;
            push_cmd.operand = req_data.elem_value;
         end
         REQ_RUN: begin
            keep = (req_data.op_code inside {[OP_ADD : OP_TRANSPOSE]});
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_ready = !q_status.full;
   assign push      = req_valid && req_ready && keep;

endmodule

@@ hdl/smau_queue.sv @@
// ----------------------------------------------------------------------------
// smau_queue
// Short command FIFO between the front and the back.
// ----------------------------------------------------------------------------
module smau_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  smau_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output smau_pkg::cmd_type          head_cmd,
   output smau_pkg::queue_status_type q_status
);
   import smau_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd       = entry_ff[rd_ptr_ff];
   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));

endmodule

@@ hdl/smau_back.sv @@
// ----------------------------------------------------------------------------
// smau_back
// Sequencer and datapath: write loads, walk result elements, drive output.
// ----------------------------------------------------------------------------
`include "small_matrix_alu_unit_defines.svh"

module smau_back (
   input  logic                       clock,
   input  logic                       reset,
   input  smau_pkg::cmd_type          head_cmd,
   input  smau_pkg::queue_status_type q_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output smau_pkg::rsp_payload_type  rsp_data
);
   import smau_pkg::*;

   localparam int FRAC_BITS = 16;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32'h8000);
   localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_MUL,
      S_ACC,
      S_FIN
   } state_type;

   state_type                 state_ff, state_in;
   op_type                    op_ff, op_in;
   logic signed [31:0]        scale_ff, scale_in;
   logic [IDX_W-1:0]          k_ff, k_in;
   logic [DIM_W-1:0]          row_ff, row_in;
   logic [DIM_W-1:0]          col_ff, col_in;
   logic [DIM_W-1:0]          m_ff, m_in;
   logic signed [63:0]        prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_data_ff, rsp_data_in;

   logic                      a_wr_en, b_wr_en;
   logic [IDX_W-1:0]          wr_addr;
   logic [IDX_W-1:0]          a_rd_addr, b_rd_addr;
   logic [31:0]               a_rd_data, b_rd_data;
   logic signed [31:0]        a_val, b_val;
   logic signed [ACC_W-1:0]   rnd_sum, rnd_val, fin_val;
   logic                      fin_sat;
   logic [31:0]               fin_word;
   logic                      out_free;
   logic                      start;

   smau_ram #(.WIDTH(32), .DEPTH(CELLS)) u_ram_a (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (wr_addr),
      .wr_data (head_cmd.operand),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   smau_ram #(.WIDTH(32), .DEPTH(CELLS)) u_ram_b (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (wr_addr),
      .wr_data (head_cmd.operand),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   assign start   = (state_ff == S_IDLE) && !q_status.empty;
   assign pop     = start;
   assign wr_addr = IDX_W'(head_cmd.index);
   assign a_wr_en = start && (head_cmd.kind == CMD_LOAD_A);
   assign b_wr_en = start && (head_cmd.kind == CMD_LOAD_B);

   assign a_val = a_rd_data;
   assign b_val = b_rd_data;

   // element addresses for the current step
   always_comb begin
      case (op_ff)
         OP_MUL: begin
            a_rd_addr = IDX_W'(row_ff) * IDX_W'(DIM) + IDX_W'(m_ff);
            b_rd_addr = IDX_W'(m_ff) * IDX_W'(DIM) + IDX_W'(col_ff);
         end
         OP_TRANSPOSE: begin
            a_rd_addr = IDX_W'(col_ff) * IDX_W'(DIM) + IDX_W'(row_ff);
            b_rd_addr = k_ff;
         end
         default: begin
            a_rd_addr = k_ff;
            b_rd_addr = k_ff;
         end
      endcase
   end

   // round multiply and scale results half up from Q32.32, then clip to 32 bits
   always_comb begin
      rnd_sum = acc_ff + ROUND_HALF;
      rnd_val = rnd_sum >>> FRAC_BITS;
      fin_val = (op_ff inside {OP_ADD, OP_SUB, OP_TRANSPOSE}) ? acc_ff : rnd_val;
      fin_sat = 1'b1;
      if (fin_val > SAT_HI) begin
         fin_word = SAT_HI[31:0];
      end else if (fin_val < SAT_LO) begin
         fin_word = SAT_LO[31:0];
      end else begin
         fin_word = fin_val[31:0];
         fin_sat  = 1'b0;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      scale_in     = scale_ff;
      k_in         = k_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      m_in         = m_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (start && (head_cmd.kind == CMD_RUN)) begin
               op_in    = head_cmd.op;
               scale_in = head_cmd.operand;
               k_in     = '0;
               row_in   = '0;
               col_in   = '0;
               m_in     = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            case (op_ff)
               OP_ADD:   prod_in = {{32{a_val[31]}}, a_val} + {{32{b_val[31]}}, b_val};
               OP_SUB:   prod_in = {{32{a_val[31]}}, a_val} - {{32{b_val[31]}}, b_val};
               OP_MUL:   prod_in = a_val * b_val;
               OP_SCALE: prod_in = a_val * scale_ff;
               default:  prod_in = {{32{a_val[31]}}, a_val};
            endcase
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in = ((m_ff == '0) ? '0 : acc_ff) + {{(ACC_W-64){prod_ff[63]}}, prod_ff};
            if ((op_ff == OP_MUL) && (m_ff != DIM_W'(DIM - 1))) begin
               m_in     = m_ff + 1'b1;
               state_in = S_READ;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.out_index     = 4'(k_ff);
               rsp_data_in.out_value     = fin_word;
               rsp_data_in.out_last      = (k_ff == IDX_W'(CELLS - 1));
               rsp_data_in.out_saturated = fin_sat;
               m_in = '0;
               k_in = k_ff + 1'b1;
               if (col_ff == DIM_W'(DIM - 1)) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
               state_in = (k_ff == IDX_W'(CELLS - 1)) ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      scale_ff    <= scale_in;
      k_ff        <= k_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      m_ff        <= m_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SMAU_ASSERT_NOW(a_pop_only_idle, clock, reset, pop, (state_ff == S_IDLE) && !q_status.empty, "queue popped outside idle")
   `SMAU_ASSERT_NOW(a_write_only_idle, clock, reset, a_wr_en || b_wr_en, state_ff == S_IDLE, "matrix written during a run")
   `SMAU_ASSERT_NOW(a_step_only_mul, clock, reset, (m_ff != '0) && (state_ff != S_IDLE), op_ff == OP_MUL, "inner step advanced outside multiply")
   `SMAU_ASSERT_NEXT(a_fin_emits, clock, reset, (state_ff == S_FIN) && out_free, rsp_valid_ff, "finished element not presented")

endmodule

@@ dv/small_matrix_alu_unit_tb.sv @@
// ----------------------------------------------------------------------------
// small_matrix_alu_unit_tb
// Self-checking bench for the 4x4 fixed-point matrix ALU. It keeps a mirror
// of both matrices and computes every element a run must stream. Sends come
// in random bursts and the result side stalls on its own pattern. Each
// streamed element is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module small_matrix_alu_unit_tb;

   import smau_pkg::*;

   // codes the block must ignore
   localparam logic [1:0] REQ_UNUSED      = 2'd3;
   localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

   localparam int RANDOM_ITEMS = 115;
   localparam int IDLE_LIMIT   = 4000;   // cycles with no transfer on either side
   localparam int DRAIN_CYCLES = 250;    // covers a full multiply run

   localparam logic signed [67:0] Q16_MAX  = 68'sd2147483647;
   localparam logic signed [67:0] Q16_MIN  = -68'sd2147483648;
   localparam logic signed [67:0] HALF_LSB = 68'sd32768;

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;

   // mirror of the matrix storage and the elements still to arrive
   logic signed [31:0] mirror_a [CELLS];
   logic signed [31:0] mirror_b [CELLS];
   rsp_payload_type    pending_elems [$];

   int mismatch_count = 0;
   int burst_left     = 0;
   int stall_mode     = 0;
   int stall_left     = 0;
   int idle_cycles    = 0;

   small_matrix_alu_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Round a Q32.32 quantity to Q16.16, half up: add half an LSB, then floor.
   function automatic logic signed [67:0] round_to_q16(logic signed [67:0] q32);
      return (q32 + HALF_LSB) >>> 16;
   endfunction

   // Clip to the signed 32-bit range and flag when clipping happened.
   function automatic void clip_q16(input logic signed [67:0] wide,
                                    output logic signed [31:0] value,
                                    output logic clipped);
      clipped = 1'b1;
      if (wide > Q16_MAX) begin
         value = Q16_MAX[31:0];
      end else if (wide < Q16_MIN) begin
         value = Q16_MIN[31:0];
      end else begin
         value   = wide[31:0];
         clipped = 1'b0;
      end
   endfunction

   // Queue every element one run streams, in row-major order.
   task automatic predict_matrix_run(op_type op, logic signed [31:0] scalar);
      logic signed [67:0] wide;
      rsp_payload_type    elem;
      int                 row;
      int                 col;
      for (int k = 0; k < CELLS; k++) begin
         row = k / DIM;
         col = k % DIM;
         elem.out_saturated = 1'b0;
         case (op)
            OP_ADD: begin
               wide = mirror_a[k] + mirror_b[k];
               clip_q16(wide, elem.out_value, elem.out_saturated);
            end
            OP_SUB: begin
               wide = mirror_a[k] - mirror_b[k];
               clip_q16(wide, elem.out_value, elem.out_saturated);
            end
            OP_MUL: begin
               // exact sum of Q32.32 products, rounded once at the end
               wide = '0;
               for (int m = 0; m < DIM; m++) begin
                  wide = wide + mirror_a[row * DIM + m] * mirror_b[m * DIM + col];
               end
               clip_q16(round_to_q16(wide), elem.out_value, elem.out_saturated);
            end
            OP_SCALE: begin
               wide = mirror_a[k] * scalar;
               clip_q16(round_to_q16(wide), elem.out_value, elem.out_saturated);
            end
            default: begin
               elem.out_value = mirror_a[col * DIM + row];
            end
         endcase
         elem.out_index = 4'(k);
         elem.out_last  = (k == CELLS - 1);
         pending_elems.push_back(elem);
      end
   endtask

   // Advance the mirror by one accepted transfer.
   task automatic track_request(req_payload_type item);
      case (item.req_type)
         REQ_LOAD_A: mirror_a[item.elem_index] = item.elem_value;
         REQ_LOAD_B: mirror_b[item.elem_index] = item.elem_value;
         REQ_RUN: begin
            if (item.op_code <= OP_TRANSPOSE) begin
               predict_matrix_run(op_type'(item.op_code), item.scale_factor);
            end
         end
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic logic signed [31:0] corner_q16(int sel);
      case (sel % 8)
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return 32'sh0000_0000;
         3:       return 32'shFFFF_FFFF;
         4:       return 32'sh0000_0001;
         5:       return 32'sh0001_0000;
         6:       return 32'shFFFF_0000;
         default: return 32'sh0000_8000;
      endcase
   endfunction

   // Mix small, medium, corner and full-range values so both the exact
   // and the saturating paths get traffic.
   function automatic logic signed [31:0] random_q16();
      logic signed [31:0] v;
      case ($urandom_range(0, 3))
         0: begin
            v = $urandom_range(0, 32'h0008_0000);
            v = v - 32'sh0004_0000;
         end
         1: begin
            v = $urandom_range(0, 32'h01FF_FFFF);
            v = v - 32'sh0100_0000;
         end
         2:       v = corner_q16($urandom_range(0, 7));
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // Drive one transfer at the falling edge and hold it until accepted.
   // The sender works in bursts; between bursts valid drops for a random gap, which may be zero.
   task automatic send_item(req_payload_type item);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 12);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      track_request(item);
   endtask

   // Load one element; the fields a load does not use carry noise.
   task automatic send_load(logic [1:0] kind, logic [3:0] index, logic signed [31:0] value);
      req_payload_type item;
      item.req_type     = kind;
      item.elem_index   = index;
      item.elem_value   = value;
      item.op_code      = 3'($urandom);
      item.scale_factor = $urandom;
      send_item(item);
   endtask

   // Start one run; the load fields carry noise.
   task automatic send_run(logic [2:0] op, logic signed [31:0] scalar);
      req_payload_type item;
      item.req_type     = REQ_RUN;
      item.elem_index   = 4'($urandom);
      item.elem_value   = $urandom;
      item.op_code      = op;
      item.scale_factor = scalar;
      send_item(item);
   endtask

   // ------------------------------------------------------------------------
   // Result side: stall pattern, checker, watchdog
   // ------------------------------------------------------------------------

   // Stall in phases: always ready, coin flip, or mostly stalled.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Compare each transferred element with the oldest prediction.
   always @(posedge clock) begin : check_results
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_elems.size() == 0) begin
            $error("unexpected result: index %0d value %0d", rsp_data.out_index,
                   rsp_data.out_value);
            mismatch_count++;
         end else begin
            want = pending_elems.pop_front();
            if (rsp_data.out_index !== want.out_index) begin
               $error("out_index: expected %0d, got %0d", want.out_index,
                      rsp_data.out_index);
               mismatch_count++;
            end
            if (rsp_data.out_value !== want.out_value) begin
               $error("out_value: expected %0d, got %0d", want.out_value,
                      rsp_data.out_value);
               mismatch_count++;
            end
            if (rsp_data.out_last !== want.out_last) begin
               $error("out_last: expected %0d, got %0d", want.out_last,
                      rsp_data.out_last);
               mismatch_count++;
            end
            if (rsp_data.out_saturated !== want.out_saturated) begin
               $error("out_saturated: expected %0d, got %0d", want.out_saturated,
                      rsp_data.out_saturated);
               mismatch_count++;
            end
         end
      end
   end

   // End the run if neither side moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $error("no transfer for %0d cycles", IDLE_LIMIT);
         $display("small_matrix_alu_unit_tb: FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Fill A with corner values, then exercise the ops that read A only.
   // Scaling by one half on an odd LSB checks rounding half up on both signs.
   task automatic test_unary_ops();
      for (int k = 0; k < CELLS; k++) begin
         send_load(REQ_LOAD_A, 4'(k), corner_q16(k));
      end
      send_run(OP_TRANSPOSE, $urandom);
      send_run(OP_SCALE, 32'sh0000_8000);
      send_run(OP_SCALE, -32'sh0000_8000);
      send_run(OP_SCALE, 32'sh7FFF_FFFF);
      send_run(OP_SCALE, 32'sh8000_0000);
   endtask

   // Fill B with shifted corners, then exercise the two-operand ops.
   task automatic test_binary_ops();
      for (int k = 0; k < CELLS; k++) begin
         send_load(REQ_LOAD_B, 4'(k), corner_q16(k + 3));
      end
      send_run(OP_ADD, $urandom);
      send_run(OP_SUB, $urandom);
      send_run(OP_MUL, $urandom);
   endtask

   // Unused request type and unused op codes produce nothing. With DIM 4 a
   // load index can never fall outside the matrix.
   task automatic test_ignored_items();
      req_payload_type item;
      logic [95:0]     noise;
      noise             = {$urandom, $urandom, $urandom};
      item              = noise[$bits(req_payload_type)-1:0];
      item.req_type     = REQ_UNUSED;
      send_item(item);
      send_run(OP_FIRST_UNUSED, $urandom);
      send_run(OP_LAST_UNUSED, $urandom);
   endtask

   // Mostly loads and valid runs with random content; the rest is noise that
   // the block must drop and that does not count toward the item total.
   task automatic test_random_traffic();
      req_payload_type item;
      logic [95:0]     noise;
      int              counted;
      int              pick;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            send_load($urandom_range(0, 1) ? REQ_LOAD_B : REQ_LOAD_A, 4'($urandom),
                      random_q16());
            counted++;
         end else if (pick < 90) begin
            send_run(3'($urandom_range(OP_ADD, OP_TRANSPOSE)), random_q16());
            counted++;
         end else if (pick < 95) begin
            noise         = {$urandom, $urandom, $urandom};
            item          = noise[$bits(req_payload_type)-1:0];
            item.req_type = REQ_UNUSED;
            send_item(item);
         end else begin
            send_run(3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED)), $urandom);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_unary_ops();
      test_binary_ops();
      test_ignored_items();
      test_random_traffic();

      // drop valid, drain all predictions, then watch for stray results
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_elems.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("small_matrix_alu_unit_tb: PASS");
      end else begin
         $display("small_matrix_alu_unit_tb: FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/smau_pkg.sv
hdl/smau_ram.sv
hdl/smau_front.sv
hdl/smau_queue.sv
hdl/smau_back.sv
hdl/small_matrix_alu_unit.sv
dv/small_matrix_alu_unit_tb.sv
